FILE: src/mrpt_pkg.sv
package mrpt_pkg;

  localparam int DEF_WIDTH  = 64;
  localparam int NUM_SMALL  = 12;
  localparam int SP_W       = 6;
  localparam int NUM_BASES  = 7;
  localparam int BASE_W     = 31;
  localparam int BIDX_W     = 3;

  localparam logic [SP_W-1:0] SMALL_PRIMES [NUM_SMALL] = '{
    6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
  };

  localparam logic [BASE_W-1:0] MR_BASES [NUM_BASES] = '{
    31'd2, 31'd325, 31'd9375, 31'd28178, 31'd450775, 31'd9780504, 31'd1795265022
  };

  // Outcome of trial division by the small primes.
  typedef struct packed {
    logic equal;
    logic divisible;
  } trial_res_t;

endpackage

FILE: src/mrpt_trial.sv
module mrpt_trial #(
  parameter int WIDTH = mrpt_pkg::DEF_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [WIDTH-1:0]       value,
  output logic                   done,
  output mrpt_pkg::trial_res_t   res
);
  import mrpt_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] sh_r;
  logic [SP_W-1:0]  rem_r [NUM_SMALL];
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             equal_r;
  logic [SP_W-1:0]  rem_nxt [NUM_SMALL];
  logic             div_any;

  // Remainders are built MSB first: r = (2r + bit) mod q, one subtract per lane.
  always_comb begin
    logic [SP_W:0] v;
    div_any = 1'b0;
    for (int k = 0; k < NUM_SMALL; k++) begin
      v = {rem_r[k], sh_r[WIDTH-1]};
      if (v >= {1'b0, SMALL_PRIMES[k]}) v = v - {1'b0, SMALL_PRIMES[k]};
      rem_nxt[k] = v[SP_W-1:0];
      if (rem_r[k] == '0) div_any = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r    <= value;
      equal_r <= 1'b0;
      for (int k = 0; k < NUM_SMALL; k++) begin
        rem_r[k] <= '0;
        if (value == WIDTH'(SMALL_PRIMES[k])) equal_r <= 1'b1;
      end
    end else if (busy_r) begin
      sh_r <= sh_r << 1;
      for (int k = 0; k < NUM_SMALL; k++) rem_r[k] <= rem_nxt[k];
    end
  end

  assign done          = done_r;
  assign res.equal     = equal_r;
  assign res.divisible = div_any;

endmodule

FILE: src/mrpt_modmul.sv
module mrpt_modmul #(
  parameter int WIDTH = mrpt_pkg::DEF_WIDTH,
  parameter int YW    = mrpt_pkg::DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [YW-1:0]    y,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] prod
);

  localparam int CW = $clog2(YW + 1);

  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] x_r;
  logic [WIDTH-1:0] m_r;
  logic [YW-1:0]    y_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [WIDTH+1:0] t;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;
  logic [WIDTH-1:0] acc_nxt;

  // One bit of y per cycle: acc = (2*acc + bit*x) mod m. The sum stays below
  // 3m, so at most 2m is taken off.
  always_comb begin
    m1 = {2'b00, m_r};
    m2 = {1'b0, m_r, 1'b0};
    t  = {1'b0, acc_r, 1'b0} + (y_r[YW-1] ? {2'b00, x_r} : '0);
    if (t >= m2)      acc_nxt = WIDTH'(t - m2);
    else if (t >= m1) acc_nxt = WIDTH'(t - m1);
    else              acc_nxt = WIDTH'(t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(YW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= x;
      y_r   <= y;
      m_r   <= m;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= y_r << 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

FILE: src/miller_rabin_prime_test.sv
// Deterministic Miller-Rabin primality test for unsigned candidates.
//
// A transaction on the input side is accepted at a rising edge where start is
// high and busy is low; in_candidate is sampled then, and only its low WIDTH
// bits are tested. busy stays high until the verdict has been delivered.
// The verdict appears on out_is_prime for exactly one cycle, marked by
// out_valid. The receiver cannot hold it off, so nothing ever stalls.
//
// Candidates below 2 go straight to the verdict. Trial division by the
// primes 2 to 37 follows for the rest and settles most composites. The
// remaining candidates go through up to seven strong probable-prime rounds.
// Every modular multiplication runs through one shared bit-serial unit, and
// a round needs about 2*WIDTH of them. That single multiplier sets the
// rate: one candidate is in flight at a time.
//
// Reset (rst_n low at a clock edge) returns the controller to idle and drops
// any transaction in progress; no result is produced for it.
module miller_rabin_prime_test #(
  parameter int WIDTH = mrpt_pkg::DEF_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_candidate,
  output logic        out_valid,
  output logic        out_is_prime
);
  import mrpt_pkg::*;

  localparam int YW = (WIDTH > BASE_W) ? WIDTH : BASE_W;
  localparam int SW = $clog2(WIDTH);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_TRIAL = 10'b0000000010,
    S_SPLIT = 10'b0000000100,
    S_RED   = 10'b0000001000,
    S_POW   = 10'b0000010000,
    S_PMUL  = 10'b0000100000,
    S_PSQR  = 10'b0001000000,
    S_CHECK = 10'b0010000000,
    S_SQL   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t            state_r;
  logic [WIDTH-1:0]  cand_r;
  logic [WIDTH-1:0]  pm1_r;
  logic [WIDTH-1:0]  d_r;
  logic [WIDTH-1:0]  e_r;
  logic [WIDTH-1:0]  r_r;
  logic [WIDTH-1:0]  b_r;
  logic [SW-1:0]     s_r;
  logic [SW-1:0]     i_r;
  logic [BIDX_W-1:0] k_r;
  logic              issued_r;
  logic              res_r;

  logic [WIDTH-1:0]  cand_in;
  logic              accept;
  logic              trial_start;
  logic              trial_done;
  trial_res_t        trial_res;

  logic              mm_start;
  logic [WIDTH-1:0]  mm_x;
  logic [YW-1:0]     mm_y;
  logic              mm_done;
  logic [WIDTH-1:0]  mm_prod;

  assign cand_in     = in_candidate[WIDTH-1:0];
  assign accept      = start && (state_r == S_IDLE);
  assign trial_start = accept && (cand_in >= WIDTH'(2));

  mrpt_trial #(.WIDTH(WIDTH)) u_trial (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trial_start),
    .value (cand_in),
    .done  (trial_done),
    .res   (trial_res)
  );

  // Operands of the shared multiplier depend on which step is running.
  // Base reduction is the product 1 * base mod p, valid because p >= 41.
  always_comb begin
    mm_start = 1'b0;
    mm_x     = b_r;
    mm_y     = YW'(b_r);
    unique case (state_r)
      S_RED: begin
        mm_start = !issued_r;
        mm_x     = WIDTH'(1);
        mm_y     = YW'(MR_BASES[k_r]);
      end
      S_PMUL: begin
        mm_start = !issued_r;
        mm_x     = r_r;
        mm_y     = YW'(b_r);
      end
      S_PSQR: begin
        mm_start = !issued_r;
      end
      S_SQL: begin
        mm_start = !issued_r && (i_r < s_r);
        mm_x     = r_r;
        mm_y     = YW'(r_r);
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  mrpt_modmul #(.WIDTH(WIDTH), .YW(YW)) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .x     (mm_x),
    .y     (mm_y),
    .m     (cand_r),
    .done  (mm_done),
    .prod  (mm_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      k_r      <= '0;
      res_r    <= 1'b0;
    end else begin
      if (mm_start) issued_r <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cand_r <= cand_in;
            if (cand_in < WIDTH'(2)) begin
              res_r   <= 1'b0;
              state_r <= S_OUT;
            end else begin
              state_r <= S_TRIAL;
            end
          end
        end
        S_TRIAL: begin
          if (trial_done) begin
            pm1_r <= cand_r - 1'b1;
            d_r   <= cand_r - 1'b1;
            s_r   <= '0;
            if (trial_res.equal) begin
              res_r   <= 1'b1;
              state_r <= S_OUT;
            end else if (trial_res.divisible) begin
              res_r   <= 1'b0;
              state_r <= S_OUT;
            end else begin
              state_r <= S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          // Strip factors of two from p - 1, one per cycle.
          if (!d_r[0]) begin
            d_r <= d_r >> 1;
            s_r <= s_r + 1'b1;
          end else begin
            k_r     <= '0;
            state_r <= S_RED;
          end
        end
        S_RED: begin
          if (mm_done) begin
            issued_r <= 1'b0;
            if (mm_prod == '0) begin
              // A base that is a multiple of p passes.
              if (k_r == BIDX_W'(NUM_BASES - 1)) begin
                res_r   <= 1'b1;
                state_r <= S_OUT;
              end else begin
                k_r <= k_r + 1'b1;
              end
            end else begin
              r_r     <= WIDTH'(1);
              b_r     <= mm_prod;
              e_r     <= d_r;
              state_r <= S_POW;
            end
          end
        end
        S_POW: begin
          if (e_r == '0) state_r <= S_CHECK;
          else if (e_r[0]) state_r <= S_PMUL;
          else state_r <= S_PSQR;
        end
        S_PMUL: begin
          if (mm_done) begin
            issued_r <= 1'b0;
            r_r      <= mm_prod;
            state_r  <= S_PSQR;
          end
        end
        S_PSQR: begin
          if (mm_done) begin
            issued_r <= 1'b0;
            b_r      <= mm_prod;
            e_r      <= e_r >> 1;
            state_r  <= S_POW;
          end
        end
        S_CHECK: begin
          i_r <= SW'(1);
          if (r_r == WIDTH'(1) || r_r == pm1_r) begin
            if (k_r == BIDX_W'(NUM_BASES - 1)) begin
              res_r   <= 1'b1;
              state_r <= S_OUT;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_RED;
            end
          end else begin
            state_r <= S_SQL;
          end
        end
        S_SQL: begin
          if (!issued_r && (i_r >= s_r)) begin
            // The squaring chain never reached p - 1: this base is a witness.
            res_r   <= 1'b0;
            state_r <= S_OUT;
          end else if (mm_done) begin
            issued_r <= 1'b0;
            r_r      <= mm_prod;
            if (mm_prod == pm1_r) begin
              if (k_r == BIDX_W'(NUM_BASES - 1)) begin
                res_r   <= 1'b1;
                state_r <= S_OUT;
              end else begin
                k_r     <= k_r + 1'b1;
                state_r <= S_RED;
              end
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end
        S_OUT: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = (state_r == S_OUT);
  assign out_is_prime = res_r;

  // An accepted transaction makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // The verdict strobe lasts one cycle and is followed by idle.
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe not followed by idle");

  // The multiplier is never restarted while a product is outstanding.
  a_mm_single: assert property (@(posedge clk) disable iff (!rst_n)
    mm_start |=> !mm_start)
    else $error("multiplier started twice");

endmodule
